### hdl/singleton_ideal_filter_top_macros.svh
// Assertion macros shared by the singleton ideal filter checker
`ifndef SINGLETON_IDEAL_FILTER_TOP_MACROS_SVH
`define SINGLETON_IDEAL_FILTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define SIF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define SIF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sif_pkg.sv
// Types and constants for the singleton ideal filter
package sif_pkg;

  localparam logic [47:0] SMALL_LIMIT  = 48'd1000;
  localparam logic [31:0] DELETE_MARK  = 32'd126;
  localparam logic [31:0] FIRST_NUMBER = 32'd127;
  localparam logic [39:0] FREE_BASE    = 40'h80_0000_0000;
  localparam logic [3:0]  TARGET_RESET = 4'd7;

  // Request action codes
  localparam logic ACT_PAIR  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // One held ideal of the current group
  typedef struct packed {
    logic [47:0] root;
    logic        side;
    logic [38:0] relation;
    logic [31:0] number;
    logic        single;
  } sif_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_REP,
    ST_FL_START,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_NUM_RD,
    ST_NUM_PROC,
    ST_FR_RD,
    ST_FR_PROC,
    ST_DEL_RD,
    ST_DEL_PROC,
    ST_FL_END
  } sif_state_t;

endpackage

### hdl/sif_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module sif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/singleton_ideal_filter_top.sv
// Singleton ideal filter: group list in RAM, sequencer for numbering and flushes
//
//   channel  | signals                                        | direction
//   ---------+------------------------------------------------+----------
//   cfg      | cfg_wr_en, cfg_wr_data                         | in
//   in       | in_valid/in_ready, action, prime, root, side, relation | in
//   out      | out_valid/out_ready, relation, value, overflow, last   | out
//
// One request at a time. Small counts and new ideals of the current prime end in the
// decide state, a repeat of a singleton ends in the repeat state. A flush (prime change or
// end of stream) adds a scan read/check per held entry, then a read/process per entry for
// each numbering, free relation or delete pass: every group access goes through the one
// registered RAM read port. Reset is synchronous, active low; the group RAM needs no
// clearing pass. A stalled output holds the sequencer on the entry being emitted.
module singleton_ideal_filter_top
  import sif_pkg::*;
#(
  parameter int GROUP_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [47:0] in_prime,
  input  logic [47:0] in_root,
  input  logic        in_is_algebraic,
  input  logic [38:0] in_relation,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [39:0] out_relation,
  output logic [31:0] out_value,
  output logic        out_overflow,
  output logic        out_last
);

  localparam int IW = $clog2(GROUP_DEPTH);
  localparam int CW = $clog2(GROUP_DEPTH + 2);
  localparam int EW = $bits(sif_entry_t);

  sif_state_t  state_r, state_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] last_single_r, last_single_nxt;
  logic          blocked_r, blocked_nxt;
  logic          has_single_r, has_single_nxt;
  logic          act_r, act_nxt;
  logic          small_r, small_nxt;
  logic          same_r, same_nxt;
  logic [47:0]   prime_r, prime_nxt;
  logic [47:0]   root_r, root_nxt;
  logic          side_r, side_nxt;
  logic [38:0]   rel_r, rel_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [47:0]   cur_prime_r, cur_prime_nxt;
  logic          prime_valid_r, prime_valid_nxt;
  logic [31:0]   next_num_r, next_num_nxt;
  logic [38:0]   free_cnt_r, free_cnt_nxt;
  logic [39:0]   free_rel_r, free_rel_nxt;
  logic [31:0]   rep_num_r, rep_num_nxt;
  logic [3:0]    target_r;

  logic          out_valid_r;
  logic [39:0]   out_rel_r;
  logic [31:0]   out_val_r;
  logic          out_ovf_r;
  logic          out_last_r;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  sif_entry_t    ram_wdata;
  logic [EW-1:0] ram_rdata;
  sif_entry_t    rd_entry;

  logic          emit, emit_ovf, emit_last, take;
  logic [39:0]   emit_rel;
  logic [31:0]   emit_val;
  logic          out_free, accept;
  logic [CW-1:0] held, held_m1;
  logic          count_ok, tail_k, root_hit, blk, hs;

  sif_ram #(
    .WIDTH (EW),
    .DEPTH (GROUP_DEPTH)
  ) u_group_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = sif_entry_t'(ram_rdata);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // An overflowed group still holds GROUP_DEPTH entries
  assign held     = (count_r > CW'(GROUP_DEPTH)) ? CW'(GROUP_DEPTH) : count_r;
  assign held_m1  = held - 1'b1;
  assign tail_k   = (k_r == held_m1[IW-1:0]);
  assign count_ok = (count_r != '0) && (count_r <= CW'(GROUP_DEPTH)) &&
                    (32'(count_r) == 32'(target_r));
  assign root_hit = rd_entry.side && ({1'b0, rd_entry.root} == {cur_prime_r, 1'b1});
  assign blk      = blocked_r || root_hit;
  assign hs       = has_single_r || rd_entry.single;

  always_comb begin
    state_nxt       = state_r;
    k_nxt           = k_r;
    last_single_nxt = last_single_r;
    blocked_nxt     = blocked_r;
    has_single_nxt  = has_single_r;
    act_nxt         = act_r;
    small_nxt       = small_r;
    same_nxt        = same_r;
    prime_nxt       = prime_r;
    root_nxt        = root_r;
    side_nxt        = side_r;
    rel_nxt         = rel_r;
    count_nxt       = count_r;
    cur_prime_nxt   = cur_prime_r;
    prime_valid_nxt = prime_valid_r;
    free_cnt_nxt    = free_cnt_r;
    free_rel_nxt    = free_rel_r;
    rep_num_nxt     = rep_num_r;
    ram_re          = 1'b0;
    ram_raddr       = k_r;
    ram_we          = 1'b0;
    ram_waddr       = k_r;
    ram_wdata       = rd_entry;
    emit            = 1'b0;
    emit_rel        = '0;
    emit_val        = '0;
    emit_ovf        = 1'b0;
    emit_last       = 1'b0;
    take            = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_nxt   = in_action;
          small_nxt = (in_prime < SMALL_LIMIT);
          same_nxt  = prime_valid_r && (in_prime == cur_prime_r);
          prime_nxt = in_prime;
          root_nxt  = in_root;
          side_nxt  = in_is_algebraic;
          rel_nxt   = in_relation;
          // fetch the tail entry for the repeat check
          ram_re    = 1'b1;
          ram_raddr = held_m1[IW-1:0];
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (act_r == ACT_FLUSH) begin
          state_nxt = ST_FL_START;
        end else if (small_r) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_rel  = {1'b0, rel_r};
            emit_val  = prime_r[31:0];
            emit_last = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (same_r && count_r != '0 && rd_entry.root == root_r &&
                     rd_entry.side == side_r) begin
          if (rd_entry.single) begin
            if (out_free) begin
              emit             = 1'b1;
              emit_rel         = {1'b0, rd_entry.relation};
              emit_val         = next_num_r;
              take             = 1'b1;
              ram_we           = 1'b1;
              ram_waddr        = held_m1[IW-1:0];
              ram_wdata.number = next_num_r;
              ram_wdata.single = 1'b0;
              rep_num_nxt      = next_num_r;
              state_nxt        = ST_REP;
            end
          end else if (out_free) begin
            emit      = 1'b1;
            emit_rel  = {1'b0, rel_r};
            emit_val  = rd_entry.number;
            emit_last = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (same_r) begin
          if (count_r < CW'(GROUP_DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = count_r[IW-1:0];
            ram_wdata = '{root: root_r, side: side_r, relation: rel_r,
                          number: '0, single: 1'b1};
            count_nxt = count_r + 1'b1;
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            // drop the ideal and mark the group overflowed
            emit      = 1'b1;
            emit_rel  = {1'b0, rel_r};
            emit_val  = DELETE_MARK;
            emit_ovf  = 1'b1;
            emit_last = 1'b1;
            count_nxt = CW'(GROUP_DEPTH + 1);
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_FL_START;
        end
      end

      ST_REP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_rel  = {1'b0, rel_r};
          emit_val  = rep_num_r;
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_FL_START: begin
        blocked_nxt    = 1'b0;
        has_single_nxt = 1'b0;
        k_nxt          = '0;
        state_nxt      = prime_valid_r ? ST_SCAN_RD : ST_FL_END;
      end

      ST_SCAN_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        blocked_nxt    = blk;
        has_single_nxt = hs;
        if (rd_entry.single) begin
          last_single_nxt = k_r;
        end
        if (tail_k) begin
          k_nxt = '0;
          if (count_ok && !blk) begin
            free_rel_nxt = FREE_BASE + {1'b0, free_cnt_r};
            free_cnt_nxt = free_cnt_r + 1'b1;
            state_nxt    = ST_NUM_RD;
          end else if (hs) begin
            state_nxt = ST_DEL_RD;
          end else begin
            state_nxt = ST_FL_END;
          end
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end

      ST_NUM_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_NUM_PROC;
      end

      ST_NUM_PROC: begin
        if (!rd_entry.single || out_free) begin
          if (rd_entry.single) begin
            emit             = 1'b1;
            emit_rel         = {1'b0, rd_entry.relation};
            emit_val         = next_num_r;
            take             = 1'b1;
            ram_we           = 1'b1;
            ram_wdata.number = next_num_r;
            ram_wdata.single = 1'b0;
          end
          if (tail_k) begin
            k_nxt     = '0;
            state_nxt = ST_FR_RD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_NUM_RD;
          end
        end
      end

      ST_FR_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_FR_PROC;
      end

      ST_FR_PROC: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_rel  = free_rel_r;
          emit_val  = rd_entry.number;
          emit_last = tail_k;
          if (tail_k) begin
            state_nxt = ST_FL_END;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_FR_RD;
          end
        end
      end

      ST_DEL_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_DEL_PROC;
      end

      ST_DEL_PROC: begin
        if (!rd_entry.single || out_free) begin
          if (rd_entry.single) begin
            emit      = 1'b1;
            emit_rel  = {1'b0, rd_entry.relation};
            emit_val  = DELETE_MARK;
            emit_last = (k_r == last_single_r);
          end
          if (k_r == last_single_r) begin
            state_nxt = ST_FL_END;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_DEL_RD;
          end
        end
      end

      ST_FL_END: begin
        if (act_r != ACT_FLUSH) begin
          // open a fresh group with this ideal as its first entry
          ram_we          = 1'b1;
          ram_waddr       = '0;
          ram_wdata       = '{root: root_r, side: side_r, relation: rel_r,
                              number: '0, single: 1'b1};
          cur_prime_nxt   = prime_r;
          prime_valid_nxt = 1'b1;
          count_nxt       = CW'(1);
        end else begin
          prime_valid_nxt = 1'b0;
          count_nxt       = '0;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Saturating ideal number
  assign next_num_nxt = (take && next_num_r != '1) ? next_num_r + 1'b1 : next_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      cur_prime_r   <= '0;
      prime_valid_r <= 1'b0;
      next_num_r    <= FIRST_NUMBER;
      free_cnt_r    <= '0;
      target_r      <= TARGET_RESET;
      out_valid_r   <= 1'b0;
      k_r           <= '0;
      blocked_r     <= 1'b0;
      has_single_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      cur_prime_r   <= cur_prime_nxt;
      prime_valid_r <= prime_valid_nxt;
      next_num_r    <= next_num_nxt;
      free_cnt_r    <= free_cnt_nxt;
      k_r           <= k_nxt;
      blocked_r     <= blocked_nxt;
      has_single_r  <= has_single_nxt;
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_single_r <= last_single_nxt;
    act_r         <= act_nxt;
    small_r       <= small_nxt;
    same_r        <= same_nxt;
    prime_r       <= prime_nxt;
    root_r        <= root_nxt;
    side_r        <= side_nxt;
    rel_r         <= rel_nxt;
    free_rel_r    <= free_rel_nxt;
    rep_num_r     <= rep_num_nxt;
    if (emit) begin
      out_rel_r  <= emit_rel;
      out_val_r  <= emit_val;
      out_ovf_r  <= emit_ovf;
      out_last_r <= emit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_relation = out_rel_r;
  assign out_value    = out_val_r;
  assign out_overflow = out_ovf_r;
  assign out_last     = out_last_r;

endmodule

### hdl/sif_checker.sv
// Port-level checker for the singleton ideal filter, bound to the top level
`include "singleton_ideal_filter_top_macros.svh"

module sif_checker
  import sif_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [39:0] out_relation,
  input logic [31:0] out_value,
  input logic        out_overflow,
  input logic        out_last
);

  // a stalled result holds
  `SIF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_relation) && $stable(out_value) && $stable(out_last), "stalled result changed")

  // an overflowed ideal is dropped with the delete mark as the only result
  `SIF_ASSERT_NOW(a_ovf_mark, clk, rst_n, out_valid && out_overflow, out_last && out_value == DELETE_MARK, "overflow result malformed")

  // free relations carry assigned ideal numbers only
  `SIF_ASSERT_NOW(a_free_num, clk, rst_n, out_valid && out_relation[39], out_value >= FIRST_NUMBER && !out_overflow, "free relation without ideal number")

  // more results of the current request are due, so no new request is taken
  `SIF_ASSERT_NOW(a_busy_mid, clk, rst_n, out_valid && !out_last, !in_ready, "request taken mid-result")

  // one request at a time
  `SIF_ASSERT_NEXT(a_one_req, clk, rst_n, in_valid && in_ready, !in_ready, "back-to-back request taken")

endmodule

bind singleton_ideal_filter_top sif_checker u_sif_checker (.*);
